@@ rtl/clap_rhythm_detector_assert.svh @@
// Assertion macros shared by the clap rhythm detector RTL.
`ifndef CLAP_RHYTHM_DETECTOR_ASSERT_SVH
`define CLAP_RHYTHM_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CRD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crd: implication check failed");

// Next-cycle implication, checked outside reset.
`define CRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crd: next-cycle check failed");

`endif

@@ rtl/crd_pkg.sv @@
// Package for the clap rhythm detector: types, register indexes and reset values.
package crd_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 12;
   localparam int TICK_BITS_DEFAULT   = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_DETECT_THRESHOLD = 3'd0,
      REG_QUIET_LEVEL      = 3'd1,
      REG_ERROR_LIMIT      = 3'd2,
      REG_DROP_STEP        = 3'd3,
      REG_MIN_CLAP_GAP     = 3'd4,
      REG_MAX_CLAP_GAP     = 3'd5,
      REG_STALE_LIMIT      = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_THRESHOLD = 2'd0,
      PH_PEAK      = 2'd1,
      PH_DECLINE   = 2'd2,
      PH_SILENCE   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [11:0] detect_threshold;
      logic [11:0] quiet_level;
      logic [7:0]  error_limit;
      logic [7:0]  drop_step;
      logic [15:0] min_clap_gap;
      logic [15:0] max_clap_gap;
      logic [15:0] stale_limit;
   } cfg_type;

   localparam logic [11:0] DETECT_THRESHOLD_RESET = 12'd1000;
   localparam logic [11:0] QUIET_LEVEL_RESET      = 12'd500;
   localparam logic [7:0]  ERROR_LIMIT_RESET      = 8'd10;
   localparam logic [7:0]  DROP_STEP_RESET        = 8'd2;
   localparam logic [15:0] MIN_CLAP_GAP_RESET     = 16'd1000;
   localparam logic [15:0] MAX_CLAP_GAP_RESET     = 16'd8000;
   localparam logic [15:0] STALE_LIMIT_RESET      = 16'd20000;

endpackage

@@ rtl/crd_if.sv @@
// Handshake channel interfaces of the clap rhythm detector.
interface crd_req_if #(
   parameter int SAMPLE_BITS = crd_pkg::SAMPLE_BITS_DEFAULT,
   parameter int TICK_BITS   = crd_pkg::TICK_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic [TICK_BITS-1:0]   timestamp;

   modport source (output valid, output sample, output timestamp, input ready);
   modport sink   (input valid, input sample, input timestamp, output ready);
endinterface

interface crd_rsp_if;
   logic       valid;
   logic       ready;
   logic       clap_seen;
   logic       light_toggle;
   logic       light_is_on;
   logic [1:0] detector_phase;

   modport source (output valid, output clap_seen, output light_toggle,
                   output light_is_on, output detector_phase, input ready);
   modport sink   (input valid, input clap_seen, input light_toggle,
                   input light_is_on, input detector_phase, output ready);
endinterface

interface crd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [crd_pkg::CSR_INDEX_BITS-1:0] index;
   logic [crd_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/crd_csr.sv @@
// Configuration register file of the clap rhythm detector.
module crd_csr (
   input  logic              clock,
   input  logic              reset,
   crd_csr_if.sink           csr_chan,
   output crd_pkg::cfg_type  cfg
);
   import crd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            REG_DETECT_THRESHOLD: cfg_in.detect_threshold = csr_chan.data[11:0];
            REG_QUIET_LEVEL:      cfg_in.quiet_level      = csr_chan.data[11:0];
            REG_ERROR_LIMIT:      cfg_in.error_limit      = csr_chan.data[7:0];
            REG_DROP_STEP:        cfg_in.drop_step        = csr_chan.data[7:0];
            REG_MIN_CLAP_GAP:     cfg_in.min_clap_gap     = csr_chan.data;
            REG_MAX_CLAP_GAP:     cfg_in.max_clap_gap     = csr_chan.data;
            REG_STALE_LIMIT:      cfg_in.stale_limit      = csr_chan.data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_threshold <= DETECT_THRESHOLD_RESET;
         cfg_ff.quiet_level      <= QUIET_LEVEL_RESET;
         cfg_ff.error_limit      <= ERROR_LIMIT_RESET;
         cfg_ff.drop_step        <= DROP_STEP_RESET;
         cfg_ff.min_clap_gap     <= MIN_CLAP_GAP_RESET;
         cfg_ff.max_clap_gap     <= MAX_CLAP_GAP_RESET;
         cfg_ff.stale_limit      <= STALE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

@@ rtl/crd_detector.sv @@
// Four-phase clap detector with stale-tick clamp and interval capture.
module crd_detector #(
   parameter int SAMPLE_BITS = crd_pkg::SAMPLE_BITS_DEFAULT,
   parameter int TICK_BITS   = crd_pkg::TICK_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [TICK_BITS-1:0]  timestamp,
   input  crd_pkg::cfg_type      cfg,
   output logic                  clap,
   output crd_pkg::phase_type    phase_next,
   output logic [TICK_BITS-1:0]  clap_interval
);
   import crd_pkg::*;

   // threshold compares run at the wider of sample and register width
   localparam int CMP_BITS   = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
   localparam int SLOPE_BITS = ((SAMPLE_BITS > 8) ? SAMPLE_BITS : 8) + 1;

   phase_type              phase_ff, phase_in;
   logic [SAMPLE_BITS-1:0] prev_ff;
   logic [7:0]             errors_ff, errors_in;
   logic [TICK_BITS-1:0]   last_ff, last_in;
   logic [TICK_BITS-1:0]   interval_ff, interval_in;

   logic [TICK_BITS-1:0] stale_lim;
   logic [TICK_BITS-1:0] age;
   logic [TICK_BITS-1:0] last_eff;
   logic                 at_detect, falling, below_release, slope_err, sample_zero;
   logic [7:0]           errors_inc;
   logic                 err_at_limit;

   assign stale_lim = TICK_BITS'(cfg.stale_limit);
   assign age       = timestamp - last_ff;
   assign last_eff  = (age > stale_lim) ? (timestamp - stale_lim) : last_ff;

   assign at_detect     = CMP_BITS'(sample) >= CMP_BITS'(cfg.detect_threshold);
   assign below_release = CMP_BITS'(sample) <  CMP_BITS'(cfg.quiet_level);
   assign falling       = sample < prev_ff;
   assign slope_err     = (SLOPE_BITS'(sample) + SLOPE_BITS'(cfg.drop_step))
                          > SLOPE_BITS'(prev_ff);
   assign sample_zero   = (sample == '0);
   assign errors_inc    = errors_ff + 8'd1;
   assign err_at_limit  = errors_inc >= cfg.error_limit;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_THRESHOLD: begin
            if (at_detect) phase_in = PH_PEAK;
         end
         PH_PEAK: begin
            if (falling) phase_in = PH_DECLINE;
         end
         PH_DECLINE: begin
            if ((slope_err && err_at_limit) || below_release) phase_in = PH_SILENCE;
         end
         PH_SILENCE: begin
            if (sample_zero) phase_in = PH_THRESHOLD;
         end
         default: phase_in = PH_THRESHOLD;
      endcase
   end

   // phase-dependent outputs and datapath updates
   always_comb begin
      clap        = 1'b0;
      errors_in   = errors_ff;
      last_in     = last_eff;
      interval_in = interval_ff;
      case (phase_ff)
         PH_PEAK: begin
            if (falling) begin
               interval_in = timestamp - last_eff;
               last_in     = timestamp;
            end
         end
         PH_DECLINE: begin
            if (slope_err) errors_in = err_at_limit ? 8'd0 : errors_inc;
            clap = below_release;
         end
         default: begin
            clap = 1'b0;
         end
      endcase
   end

   assign phase_next    = phase_in;
   assign clap_interval = interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_THRESHOLD;
         prev_ff     <= '0;
         errors_ff   <= '0;
         last_ff     <= '0;
         interval_ff <= '0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         prev_ff     <= sample;
         errors_ff   <= errors_in;
         last_ff     <= last_in;
         interval_ff <= interval_in;
      end
   end
endmodule

@@ rtl/crd_rhythm.sv @@
// Two-step rhythm check that toggles the light on a matching clap pair.
module crd_rhythm #(
   parameter int TICK_BITS = crd_pkg::TICK_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic                 clap,
   input  logic [TICK_BITS-1:0] clap_interval,
   input  crd_pkg::cfg_type     cfg,
   output logic                 toggle,
   output logic                 light_next
);
   import crd_pkg::*;

   localparam int WIDE_BITS = TICK_BITS + 2;

   logic                 step_ff, step_in;
   logic [TICK_BITS-1:0] first_ff, first_in;
   logic                 light_ff, light_in;

   logic                 gap_ok;
   logic [WIDE_BITS-1:0] first_x4, interval_x1, interval_x3;
   logic                 ratio_ok;

   assign gap_ok = (clap_interval > TICK_BITS'(cfg.min_clap_gap))
                && (clap_interval < TICK_BITS'(cfg.max_clap_gap));

   assign first_x4    = {first_ff, 2'b00};
   assign interval_x1 = WIDE_BITS'(clap_interval);
   assign interval_x3 = interval_x1 + WIDE_BITS'({clap_interval, 1'b0});
   // quarter < first/second < three quarters, done without division
   assign ratio_ok    = (first_x4 > interval_x1) && (first_x4 < interval_x3);

   always_comb begin
      step_in  = step_ff;
      first_in = first_ff;
      toggle   = 1'b0;
      if (clap) begin
         if (!step_ff) begin
            if (gap_ok) begin
               first_in = clap_interval;
               step_in  = 1'b1;
            end
         end else begin
            step_in = 1'b0;
            toggle  = gap_ok && ratio_ok;
         end
      end
      light_in = light_ff ^ toggle;
   end

   assign light_next = light_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 1'b0;
         first_ff <= '0;
         light_ff <= 1'b1;
      end else if (fire) begin
         step_ff  <= step_in;
         first_ff <= first_in;
         light_ff <= light_in;
      end
   end
endmodule

@@ rtl/clap_rhythm_detector.sv @@
// Clap rhythm detector top level: input register, detector, rhythm check, result register.
//
// req_chan carries one envelope sample and its tick timestamp per transaction;
// rsp_chan returns exactly one result per accepted sample: clap_seen,
// light_toggle, light_is_on and detector_phase after that sample.
// csr_chan writes the seven configuration registers by index; it is always
// ready and is meant to be written only while no sample is in flight.
// A sample accepted into the input register is evaluated through one
// level of compares and small adds; its result is captured in the result
// register and presented on rsp_chan.
// Throughput: one sample per cycle while rsp_chan does not stall, set by
// the state update of the detector and rhythm registers on each sample.
// When rsp_chan stalls the result register holds, the input register holds
// its sample, and req_chan.ready drops once both are full; nothing is lost.
// Reset (synchronous, active high) empties both registers, returns the
// detector to threshold wait with the light on, and loads the register
// defaults.
module clap_rhythm_detector #(
   parameter int SAMPLE_BITS = crd_pkg::SAMPLE_BITS_DEFAULT,
   parameter int TICK_BITS   = crd_pkg::TICK_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   crd_req_if.sink    req_chan,
   crd_rsp_if.source  rsp_chan,
   crd_csr_if.sink    csr_chan
);
   import crd_pkg::*;
`include "clap_rhythm_detector_assert.svh"

   cfg_type cfg;

   logic                   in_valid_ff;
   logic [SAMPLE_BITS-1:0] in_sample_ff;
   logic [TICK_BITS-1:0]   in_ts_ff;

   logic       out_valid_ff;
   logic       out_clap_ff;
   logic       out_toggle_ff;
   logic       out_light_ff;
   phase_type  out_phase_ff;

   logic                 advance;
   logic                 fire;
   logic                 accept;
   logic                 clap;
   phase_type            phase_next;
   logic [TICK_BITS-1:0] clap_interval;
   logic                 toggle;
   logic                 light_next;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   crd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   crd_detector #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TICK_BITS   (TICK_BITS)
   ) u_detector (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .sample        (in_sample_ff),
      .timestamp     (in_ts_ff),
      .cfg           (cfg),
      .clap          (clap),
      .phase_next    (phase_next),
      .clap_interval (clap_interval)
   );

   crd_rhythm #(
      .TICK_BITS (TICK_BITS)
   ) u_rhythm (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .clap          (clap),
      .clap_interval (clap_interval),
      .cfg           (cfg),
      .toggle        (toggle),
      .light_next    (light_next)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_sample_ff <= req_chan.sample;
         in_ts_ff     <= req_chan.timestamp;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_clap_ff   <= clap;
         out_toggle_ff <= toggle;
         out_light_ff  <= light_next;
         out_phase_ff  <= phase_next;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.clap_seen      = out_clap_ff;
   assign rsp_chan.light_toggle   = out_toggle_ff;
   assign rsp_chan.light_is_on    = out_light_ff;
   assign rsp_chan.detector_phase = out_phase_ff;

   `CRD_ASSERT_IMPLY(a_toggle_needs_clap, clock, reset, out_valid_ff && out_toggle_ff, out_clap_ff)
   `CRD_ASSERT_IMPLY(a_clap_ends_silent, clock, reset, out_valid_ff && out_clap_ff, out_phase_ff == PH_SILENCE)
   `CRD_ASSERT_NEXT(a_fire_gives_result, clock, reset, fire, out_valid_ff)
   `CRD_ASSERT_NEXT(a_stalled_input_holds, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_sample_ff) && $stable(in_ts_ff))

endmodule
